FILE: sv/lca_binary_lifting_defines.svh
// Assertion helpers for the LCA block; they expect clk and rst_n in scope.
`ifndef LCA_BINARY_LIFTING_DEFINES_SVH
`define LCA_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, inactive during reset
`define LCABL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive during reset
`define LCABL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lcabl_pkg.sv
package lcabl_pkg;

  localparam int NODE_W     = 10;
  localparam int NODE_SLOTS = 1 << NODE_W;
  localparam logic [NODE_W-1:0] DEPTH_MAX = 10'd1023;

  // Input transaction op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD,
    S_B_INIT, S_ROOT_RD, S_ROOT_CHK,
    S_DEP_INIT, S_DEP, S_DEP_STEP,
    S_FILL_INIT, S_FILL_RD1, S_FILL_RD2, S_FILL_WR,
    S_Q_RDX, S_Q_RDY, S_Q_SWAP, S_L1, S_L1_UP, S_CMP,
    S_L2_RX, S_L2_RY, S_L2_CMP, S_FIN_RD, S_FIN_TAKE, S_RES
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_TAKE, DP_LOAD, DP_CLR,
    DP_B_INIT, DP_ROOT_RD, DP_ROOT_CHK,
    DP_DEP_INIT, DP_DEP_RD, DP_DEP_STEP, DP_DEP_WR,
    DP_FILL_INIT, DP_FILL_RD1, DP_FILL_RD2, DP_FILL_WR,
    DP_Q_RDX, DP_Q_RDY, DP_Q_SWAP, DP_L1_RD, DP_L1_UP, DP_L1_SKIP,
    DP_CMP_INIT, DP_L2_RX, DP_L2_RY, DP_L2_CMP, DP_FIN_RD, DP_FIN_TAKE, DP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic n_zero;
    logic i_last;
    logic walk_done;
    logic lev_zero;
    logic lev_top;
    logic dif_bit;
    logic xy_eq;
  } dp_sts_t;

endpackage

FILE: sv/lcabl_in_if.sv
interface lcabl_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [lcabl_pkg::NODE_W-1:0]  node_a;
  logic [lcabl_pkg::NODE_W-1:0]  node_b;

  modport source (output valid, op, node_a, node_b, input ready);
  modport sink   (input valid, op, node_a, node_b, output ready);
endinterface

FILE: sv/lcabl_out_if.sv
interface lcabl_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcabl_pkg::NODE_W-1:0]  ancestor;

  modport source (output valid, ancestor, input ready);
  modport sink   (input valid, ancestor, output ready);
endinterface

FILE: sv/lca_binary_lifting.sv
// Channel  | Dir | Handshake    | Payload
// in_ch    | in  | valid/ready  | op, node_a, node_b
// out_ch   | out | valid/ready  | ancestor
// cfg      | in  | cfg_we       | cfg_wdata (node_count)
//
// Query length is set by the single read port of the jump table (two reads per
// level in the joint lift). Build scans the parent flags for the root, walks
// each node up the level-0 jumps to its depth, then fills the higher levels.
// Reset and clear sweep jump table, parent flags and depths with in_ch.ready low.
// A finished result sits in the output register; the next transaction is taken
// while it waits, and only a later query result stalls on it.
`include "lca_binary_lifting_defines.svh"

module lca_binary_lifting #(
  parameter int MAX_NODES = 1023,
  parameter int LEVELS    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lcabl_in_if.sink                      in_ch,
  lcabl_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [lcabl_pkg::NODE_W-1:0]  cfg_wdata
);

  lcabl_pkg::dp_cmd_t cmd;
  lcabl_pkg::dp_sts_t sts;

  lcabl_ctrl #(.LEVELS(LEVELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lcabl_datapath #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .node_a    (in_ch.node_a),
    .node_b    (in_ch.node_b),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ancestor  (out_ch.ancestor)
  );

  // Checks
  `LCABL_ASSERT_IMP(a_take, in_ch.valid && in_ch.ready, cmd.op == lcabl_pkg::DP_TAKE, "accept without capture")
  `LCABL_ASSERT_NXT(a_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "ready right after accept")
  `LCABL_ASSERT_IMP(a_res, $rose(out_ch.valid), $past(cmd.op == lcabl_pkg::DP_RES), "result without load")

endmodule

FILE: sv/lcabl_datapath.sv
module lcabl_datapath #(
  parameter int MAX_NODES = 1023,
  parameter int LEVELS    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcabl_pkg::dp_cmd_t            cmd,
  output lcabl_pkg::dp_sts_t            sts,
  input  logic [lcabl_pkg::NODE_W-1:0]  node_a,
  input  logic [lcabl_pkg::NODE_W-1:0]  node_b,
  input  logic                          cfg_we,
  input  logic [lcabl_pkg::NODE_W-1:0]  cfg_wdata,
  output logic [lcabl_pkg::NODE_W-1:0]  ancestor
);

  localparam int NW     = lcabl_pkg::NODE_W;
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JDEPTH = LEVELS * lcabl_pkg::NODE_SLOTS;
  localparam int JAW    = $clog2(JDEPTH);
  localparam int DW     = $clog2(MAX_NODES + 1);
  localparam int DIFW   = (LEVELS > NW) ? LEVELS : NW;

  // Jump table at {level, node}, parent flags and depths per node
  logic [NW-1:0] jmem [JDEPTH];
  logic          fmem [lcabl_pkg::NODE_SLOTS];
  logic [NW-1:0] dmem [lcabl_pkg::NODE_SLOTS];

  logic [NW-1:0]   node_count_r, root_r, a_r, b_r, x_r, y_r, dx_r, i_r, cur_r;
  logic [NW-1:0]   mid_r, jx_r, anc_r, jmp_rdata_r, dep_rdata_r;
  logic            flg_rdata_r;
  logic            a_ok_r, b_ok_r;
  logic [DIFW-1:0] dif_r;
  logic [LW-1:0]   lev_r;
  logic [DW-1:0]   d_r;
  logic [JAW-1:0]  clr_r;

  logic [NW-1:0]   n_eff, dsat, x_nxt, y_nxt, dy;
  logic [LW-1:0]   lev_dn, lev_top;
  logic [DIFW-1:0] dif_sh;
  logic            a_ok, b_ok;

  logic            j_we;
  logic [JAW-1:0]  j_wa, j_ra;
  logic [NW-1:0]   j_wd;
  logic            f_we, f_wd;
  logic [NW-1:0]   f_wa, f_ra;
  logic            d_we;
  logic [NW-1:0]   d_wa, d_wd, d_ra;

  function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] lev, input logic [NW-1:0] nd);
    jaddr = JAW'({lev, nd});
  endfunction

  // Derived values
  assign n_eff   = (32'(node_count_r) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : node_count_r;
  assign dsat    = (32'(d_r) > 32'(lcabl_pkg::DEPTH_MAX)) ? lcabl_pkg::DEPTH_MAX : NW'(d_r);
  assign lev_dn  = lev_r - LW'(1);
  assign lev_top = LW'(LEVELS - 1);
  assign dif_sh  = dif_r >> lev_r;
  assign a_ok    = (node_a != '0) && (32'(node_a) <= 32'(MAX_NODES));
  assign b_ok    = (node_b != '0) && (32'(node_b) <= 32'(MAX_NODES));
  assign dy      = dep_rdata_r;
  assign x_nxt   = (32'(node_a) <= 32'(MAX_NODES)) ? node_a : '0;
  assign y_nxt   = (32'(node_b) <= 32'(MAX_NODES)) ? node_b : '0;

  // Status to the controller
  always_comb begin
    sts.clr_last  = (clr_r == JAW'(JDEPTH - 1));
    sts.n_zero    = (n_eff == '0);
    sts.i_last    = (i_r == n_eff);
    sts.walk_done = (cur_r == root_r) || (cur_r == '0) || (32'(d_r) >= 32'(MAX_NODES));
    sts.lev_zero  = (lev_r == '0);
    sts.lev_top   = (lev_r == lev_top);
    sts.dif_bit   = dif_sh[0];
    sts.xy_eq     = (x_r == y_r);
  end

  // Memory port selection
  always_comb begin
    j_we = 1'b0; j_wa = jaddr('0, b_r); j_wd = a_r; j_ra = jaddr('0, cur_r);
    f_we = 1'b0; f_wa = b_r; f_wd = 1'b1; f_ra = i_r;
    d_we = 1'b0; d_wa = i_r; d_wd = dsat; d_ra = x_r;
    case (cmd.op)
      lcabl_pkg::DP_LOAD: begin
        j_we = a_ok_r && b_ok_r;
        f_we = a_ok_r && b_ok_r;
      end
      lcabl_pkg::DP_CLR: begin
        j_we = 1'b1; j_wa = clr_r; j_wd = '0;
        f_we = 1'b1; f_wa = clr_r[NW-1:0]; f_wd = 1'b0;
        d_we = 1'b1; d_wa = clr_r[NW-1:0]; d_wd = '0;
      end
      lcabl_pkg::DP_DEP_WR:   d_we = 1'b1;
      lcabl_pkg::DP_FILL_RD1: j_ra = jaddr(lev_dn, i_r);
      lcabl_pkg::DP_FILL_RD2: j_ra = jaddr(lev_dn, jmp_rdata_r);
      lcabl_pkg::DP_FILL_WR: begin
        j_we = (mid_r != '0); j_wa = jaddr(lev_r, i_r); j_wd = jmp_rdata_r;
      end
      lcabl_pkg::DP_Q_RDY:    d_ra = y_r;
      lcabl_pkg::DP_L1_RD:    j_ra = jaddr(lev_r, x_r);
      lcabl_pkg::DP_L2_RX:    j_ra = jaddr(lev_r, x_r);
      lcabl_pkg::DP_L2_RY:    j_ra = jaddr(lev_r, y_r);
      lcabl_pkg::DP_FIN_RD:   j_ra = jaddr('0, x_r);
      default: ;
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (j_we) jmem[j_wa] <= j_wd;
    jmp_rdata_r <= jmem[j_ra];
    if (f_we) fmem[f_wa] <= f_wd;
    flg_rdata_r <= fmem[f_ra];
    if (d_we) dmem[d_wa] <= d_wd;
    dep_rdata_r <= dmem[d_ra];
  end

  // Control registers: config, root, sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NW'(1);
      root_r       <= NW'(1);
      clr_r        <= '0;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      case (cmd.op)
        lcabl_pkg::DP_CLR: begin
          root_r <= NW'(1);
          clr_r  <= sts.clr_last ? '0 : clr_r + JAW'(1);
        end
        lcabl_pkg::DP_B_INIT:   root_r <= NW'(1);
        lcabl_pkg::DP_ROOT_CHK: if (!flg_rdata_r) root_r <= i_r;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lcabl_pkg::DP_TAKE: begin
        a_r <= node_a; b_r <= node_b; a_ok_r <= a_ok; b_ok_r <= b_ok;
        x_r <= x_nxt;  y_r <= y_nxt;
      end
      lcabl_pkg::DP_B_INIT:   i_r <= NW'(1);
      lcabl_pkg::DP_ROOT_CHK: i_r <= i_r + NW'(1);
      lcabl_pkg::DP_DEP_INIT: begin
        i_r <= NW'(1); cur_r <= NW'(1); d_r <= '0;
      end
      lcabl_pkg::DP_DEP_STEP: begin
        cur_r <= jmp_rdata_r; d_r <= d_r + DW'(1);
      end
      lcabl_pkg::DP_DEP_WR: begin
        i_r <= i_r + NW'(1); cur_r <= i_r + NW'(1); d_r <= '0;
      end
      lcabl_pkg::DP_FILL_INIT: begin
        lev_r <= LW'(1); i_r <= NW'(1);
      end
      lcabl_pkg::DP_FILL_RD2: mid_r <= jmp_rdata_r;
      lcabl_pkg::DP_FILL_WR: begin
        if (sts.i_last) begin
          i_r <= NW'(1); lev_r <= lev_r + LW'(1);
        end else begin
          i_r <= i_r + NW'(1);
        end
      end
      lcabl_pkg::DP_Q_RDY: dx_r <= dep_rdata_r;
      lcabl_pkg::DP_Q_SWAP: begin
        lev_r <= lev_top;
        if (dx_r < dy) begin
          x_r <= y_r; y_r <= x_r; dif_r <= DIFW'(dy - dx_r);
        end else begin
          dif_r <= DIFW'(dx_r - dy);
        end
      end
      lcabl_pkg::DP_L1_UP: begin
        x_r <= jmp_rdata_r; lev_r <= lev_dn;
      end
      lcabl_pkg::DP_L1_SKIP:  lev_r <= lev_dn;
      lcabl_pkg::DP_CMP_INIT: lev_r <= lev_top;
      lcabl_pkg::DP_L2_RY:    jx_r <= jmp_rdata_r;
      lcabl_pkg::DP_L2_CMP: begin
        if (jx_r != jmp_rdata_r) begin
          x_r <= jx_r; y_r <= jmp_rdata_r;
        end
        lev_r <= lev_dn;
      end
      lcabl_pkg::DP_FIN_TAKE: x_r <= jmp_rdata_r;
      lcabl_pkg::DP_RES:      anc_r <= x_r;
      default: ;
    endcase
  end

  assign ancestor = anc_r;

endmodule

FILE: sv/lcabl_ctrl.sv
module lcabl_ctrl #(
  parameter int LEVELS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lcabl_pkg::dp_cmd_t  cmd,
  input  lcabl_pkg::dp_sts_t  sts
);

  lcabl_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcabl_pkg::S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = lcabl_pkg::DP_NOP;
    in_ready  = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      lcabl_pkg::S_CLR: begin
        cmd.op = lcabl_pkg::DP_CLR;
        if (sts.clr_last) state_nxt = lcabl_pkg::S_IDLE;
      end
      lcabl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = lcabl_pkg::DP_TAKE;
          case (in_op)
            lcabl_pkg::OP_LOAD:  state_nxt = lcabl_pkg::S_LOAD;
            lcabl_pkg::OP_BUILD: state_nxt = lcabl_pkg::S_B_INIT;
            lcabl_pkg::OP_QUERY: state_nxt = lcabl_pkg::S_Q_RDX;
            default:             state_nxt = lcabl_pkg::S_CLR;
          endcase
        end
      end
      lcabl_pkg::S_LOAD: begin
        cmd.op = lcabl_pkg::DP_LOAD;
        state_nxt = lcabl_pkg::S_IDLE;
      end
      // Build: root scan
      lcabl_pkg::S_B_INIT: begin
        cmd.op = lcabl_pkg::DP_B_INIT;
        state_nxt = sts.n_zero ? lcabl_pkg::S_IDLE : lcabl_pkg::S_ROOT_RD;
      end
      lcabl_pkg::S_ROOT_RD: begin
        cmd.op = lcabl_pkg::DP_ROOT_RD;
        state_nxt = lcabl_pkg::S_ROOT_CHK;
      end
      lcabl_pkg::S_ROOT_CHK: begin
        cmd.op = lcabl_pkg::DP_ROOT_CHK;
        state_nxt = sts.i_last ? lcabl_pkg::S_DEP_INIT : lcabl_pkg::S_ROOT_RD;
      end
      // Build: depth walks
      lcabl_pkg::S_DEP_INIT: begin
        cmd.op = lcabl_pkg::DP_DEP_INIT;
        state_nxt = lcabl_pkg::S_DEP;
      end
      lcabl_pkg::S_DEP: begin
        if (sts.walk_done) begin
          cmd.op = lcabl_pkg::DP_DEP_WR;
          if (sts.i_last)
            state_nxt = (LEVELS > 1) ? lcabl_pkg::S_FILL_INIT : lcabl_pkg::S_IDLE;
        end else begin
          cmd.op = lcabl_pkg::DP_DEP_RD;
          state_nxt = lcabl_pkg::S_DEP_STEP;
        end
      end
      lcabl_pkg::S_DEP_STEP: begin
        cmd.op = lcabl_pkg::DP_DEP_STEP;
        state_nxt = lcabl_pkg::S_DEP;
      end
      // Build: higher jump levels
      lcabl_pkg::S_FILL_INIT: begin
        cmd.op = lcabl_pkg::DP_FILL_INIT;
        state_nxt = lcabl_pkg::S_FILL_RD1;
      end
      lcabl_pkg::S_FILL_RD1: begin
        cmd.op = lcabl_pkg::DP_FILL_RD1;
        state_nxt = lcabl_pkg::S_FILL_RD2;
      end
      lcabl_pkg::S_FILL_RD2: begin
        cmd.op = lcabl_pkg::DP_FILL_RD2;
        state_nxt = lcabl_pkg::S_FILL_WR;
      end
      lcabl_pkg::S_FILL_WR: begin
        cmd.op = lcabl_pkg::DP_FILL_WR;
        state_nxt = (sts.i_last && sts.lev_top) ? lcabl_pkg::S_IDLE : lcabl_pkg::S_FILL_RD1;
      end
      // Query: depths and equalizing lift
      lcabl_pkg::S_Q_RDX: begin
        cmd.op = lcabl_pkg::DP_Q_RDX;
        state_nxt = lcabl_pkg::S_Q_RDY;
      end
      lcabl_pkg::S_Q_RDY: begin
        cmd.op = lcabl_pkg::DP_Q_RDY;
        state_nxt = lcabl_pkg::S_Q_SWAP;
      end
      lcabl_pkg::S_Q_SWAP: begin
        cmd.op = lcabl_pkg::DP_Q_SWAP;
        state_nxt = lcabl_pkg::S_L1;
      end
      lcabl_pkg::S_L1: begin
        if (sts.dif_bit) begin
          cmd.op = lcabl_pkg::DP_L1_RD;
          state_nxt = lcabl_pkg::S_L1_UP;
        end else begin
          cmd.op = lcabl_pkg::DP_L1_SKIP;
          if (sts.lev_zero) state_nxt = lcabl_pkg::S_CMP;
        end
      end
      lcabl_pkg::S_L1_UP: begin
        cmd.op = lcabl_pkg::DP_L1_UP;
        state_nxt = sts.lev_zero ? lcabl_pkg::S_CMP : lcabl_pkg::S_L1;
      end
      lcabl_pkg::S_CMP: begin
        cmd.op = lcabl_pkg::DP_CMP_INIT;
        state_nxt = sts.xy_eq ? lcabl_pkg::S_RES : lcabl_pkg::S_L2_RX;
      end
      // Query: joint lift
      lcabl_pkg::S_L2_RX: begin
        cmd.op = lcabl_pkg::DP_L2_RX;
        state_nxt = lcabl_pkg::S_L2_RY;
      end
      lcabl_pkg::S_L2_RY: begin
        cmd.op = lcabl_pkg::DP_L2_RY;
        state_nxt = lcabl_pkg::S_L2_CMP;
      end
      lcabl_pkg::S_L2_CMP: begin
        cmd.op = lcabl_pkg::DP_L2_CMP;
        state_nxt = sts.lev_zero ? lcabl_pkg::S_FIN_RD : lcabl_pkg::S_L2_RX;
      end
      lcabl_pkg::S_FIN_RD: begin
        cmd.op = lcabl_pkg::DP_FIN_RD;
        state_nxt = lcabl_pkg::S_FIN_TAKE;
      end
      lcabl_pkg::S_FIN_TAKE: begin
        cmd.op = lcabl_pkg::DP_FIN_TAKE;
        state_nxt = lcabl_pkg::S_RES;
      end
      // Hand result to the output register once it is free
      lcabl_pkg::S_RES: begin
        if (out_free) begin
          cmd.op = lcabl_pkg::DP_RES;
          out_valid_nxt = 1'b1;
          state_nxt = lcabl_pkg::S_IDLE;
        end
      end
      default: state_nxt = lcabl_pkg::S_IDLE;
    endcase
  end

endmodule
